>>> hdl/lbp_3x3_image_stream_defines.svh
// Assertion macros shared by the LBP stream RTL.
// Uses the clk and rst_n names of the module that includes it.
`ifndef LBP_3X3_IMAGE_STREAM_DEFINES_SVH
`define LBP_3X3_IMAGE_STREAM_DEFINES_SVH

// Condition holds at every edge out of reset.
`define LBP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent at the same edge.
`define LBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent at the next edge.
`define LBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lbp_pkg.sv
// Shared constants, types and helpers for the LBP stream block.
// No dependencies.
package lbp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIX_W      = 8;
  localparam int DIM_W      = 11;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int NB_N       = 8;

  localparam logic [DIM_W-1:0] MIN_DIM      = DIM_W'(3);
  localparam logic [DIM_W-1:0] MAX_WIDTH_D  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_HEIGHT_D = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] RST_WIDTH    = DIM_W'(640);
  localparam logic [DIM_W-1:0] RST_HEIGHT   = DIM_W'(480);

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic emit;
    logic last;
  } lbp_ctl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    if (v < MIN_DIM) begin
      res = MIN_DIM;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

>>> hdl/lbp_line_ram.sv
// Generic single-port-write, registered-read RAM for one line store.
// Read during write to the same entry returns the old data. No dependencies.
module lbp_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/lbp_code_unit.sv
// Window columns, eight neighbor compares and the result output register.
// Depends on lbp_pkg and lbp_3x3_image_stream_defines.svh.
`include "lbp_3x3_image_stream_defines.svh"

module lbp_code_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       s1_valid,
  input  lbp_pkg::lbp_ctl_t          s1_ctl,
  input  logic [lbp_pkg::PIX_W-1:0]  s1_pixel,
  input  logic [lbp_pkg::PIX_W-1:0]  s1_top,
  input  logic [lbp_pkg::PIX_W-1:0]  s1_mid,
  output logic                       advance,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lbp_pkg::PIX_W-1:0]  out_lbp_code,
  output logic                       out_frame_last
);

  logic [lbp_pkg::PIX_W-1:0] col_old_r [3];
  logic [lbp_pkg::PIX_W-1:0] col_new_r [3];
  logic [lbp_pkg::PIX_W-1:0] nb [lbp_pkg::NB_N];
  logic [lbp_pkg::PIX_W-1:0] center;
  logic [lbp_pkg::NB_N-1:0]  code_nxt;
  logic                      shift;
  logic                      out_valid_r;
  logic [lbp_pkg::PIX_W-1:0] out_code_r;
  logic                      out_last_r;

  assign advance = !out_valid_r || out_ready;
  assign shift   = s1_valid && advance;

  // center is the middle pixel of the middle column, held in col_new_r
  assign center = col_new_r[1];
  assign nb[0]  = col_old_r[0];
  assign nb[1]  = col_new_r[0];
  assign nb[2]  = s1_top;
  assign nb[3]  = col_old_r[1];
  assign nb[4]  = s1_mid;
  assign nb[5]  = col_old_r[2];
  assign nb[6]  = col_new_r[2];
  assign nb[7]  = s1_pixel;

  always_comb begin
    for (int k = 0; k < lbp_pkg::NB_N; k++) begin
      code_nxt[k] = (nb[k] >= center);
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      col_old_r[0] <= col_new_r[0];
      col_old_r[1] <= col_new_r[1];
      col_old_r[2] <= col_new_r[2];
      col_new_r[0] <= s1_top;
      col_new_r[1] <= s1_mid;
      col_new_r[2] <= s1_pixel;
      out_code_r   <= code_nxt;
      out_last_r   <= s1_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid && s1_ctl.emit;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_lbp_code   = out_code_r;
  assign out_frame_last = out_last_r;

  `LBP_ASSERT_IMP(a_rise_from_emit, $rose(out_valid_r), $past(s1_valid && s1_ctl.emit), "result without an emitting item")

endmodule

>>> hdl/lbp_3x3_image_stream.sv
// Top level of the 3x3 local binary pattern stream block.
// Depends on lbp_pkg, lbp_line_ram, lbp_code_unit and the defines header.
//
// Pixels enter in raster order at one item per clock while in_ready is high;
// each pixel reads both line stores at its column and overwrites the older
// row in the same cycle, so the line store port sets the rate at one item per
// cycle. The line store read and the stage register load at the accepting
// edge; the compare result lands in the output register once the output
// stage can advance (register empty or out_ready high). Only interior pixels
// yield a code, (W-2)x(H-2) per frame, with out_frame_last on the final one.
// Width and height clamp to 3..1024; any register write restarts the frame.
`include "lbp_3x3_image_stream_defines.svh"

module lbp_3x3_image_stream (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lbp_pkg::PIX_W-1:0]  in_pixel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lbp_pkg::PIX_W-1:0]  out_lbp_code,
  output logic                       out_frame_last,
  input  logic                       cfg_wr_en,
  input  logic [0:0]                 cfg_index,
  input  logic [lbp_pkg::DIM_W-1:0]  cfg_wdata
);

  logic [lbp_pkg::DIM_W-1:0] width_r, width_nxt;
  logic [lbp_pkg::DIM_W-1:0] height_r, height_nxt;
  logic [lbp_pkg::COL_W-1:0] col_r, col_nxt;
  logic [lbp_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [lbp_pkg::DIM_W-1:0] col_inc;
  logic [lbp_pkg::DIM_W-1:0] row_inc;
  logic                      col_end;
  logic                      row_end;
  logic                      accept;
  logic                      advance;
  logic                      s1_valid_r, s1_valid_nxt;
  lbp_pkg::lbp_ctl_t         s1_ctl_r, s1_ctl_nxt;
  logic [lbp_pkg::PIX_W-1:0] s1_pixel_r;
  logic                      s1_par_r;
  logic [lbp_pkg::PIX_W-1:0] bank0_rd;
  logic [lbp_pkg::PIX_W-1:0] bank1_rd;
  logic [lbp_pkg::PIX_W-1:0] s1_top;
  logic [lbp_pkg::PIX_W-1:0] s1_mid;

  assign in_ready = !s1_valid_r || advance;
  assign accept   = in_valid && in_ready;

  assign col_inc = {1'b0, col_r} + lbp_pkg::DIM_W'(1);
  assign row_inc = {1'b0, row_r} + lbp_pkg::DIM_W'(1);
  assign col_end = (col_inc >= width_r);
  assign row_end = (row_inc >= height_r);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (cfg_wr_en) begin
      unique case (lbp_pkg::reg_idx_t'(cfg_index))
        lbp_pkg::REG_IMAGE_WIDTH: begin
          width_nxt = lbp_pkg::clamp_dim(cfg_wdata, lbp_pkg::MAX_WIDTH_D);
        end
        lbp_pkg::REG_IMAGE_HEIGHT: begin
          height_nxt = lbp_pkg::clamp_dim(cfg_wdata, lbp_pkg::MAX_HEIGHT_D);
        end
        default: begin
          width_nxt = width_r;
        end
      endcase
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_inc[lbp_pkg::ROW_W-1:0];
      end else begin
        col_nxt = col_inc[lbp_pkg::COL_W-1:0];
      end
    end
  end

  always_comb begin
    s1_ctl_nxt.emit = (row_r >= lbp_pkg::ROW_W'(2)) && (col_r >= lbp_pkg::COL_W'(2));
    s1_ctl_nxt.last = row_end && col_end;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= lbp_pkg::RST_WIDTH;
      height_r   <= lbp_pkg::RST_HEIGHT;
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r   <= s1_ctl_nxt;
      s1_pixel_r <= in_pixel;
      s1_par_r   <= row_r[0];
    end
  end

  // even rows live in bank 0, odd rows in bank 1
  lbp_line_ram #(
    .DEPTH (lbp_pkg::MAX_WIDTH),
    .WIDTH (lbp_pkg::PIX_W)
  ) u_bank0 (
    .clk   (clk),
    .we    (accept && !row_r[0]),
    .waddr (col_r),
    .wdata (in_pixel),
    .re    (accept),
    .raddr (col_r),
    .rdata (bank0_rd)
  );

  lbp_line_ram #(
    .DEPTH (lbp_pkg::MAX_WIDTH),
    .WIDTH (lbp_pkg::PIX_W)
  ) u_bank1 (
    .clk   (clk),
    .we    (accept && row_r[0]),
    .waddr (col_r),
    .wdata (in_pixel),
    .re    (accept),
    .raddr (col_r),
    .rdata (bank1_rd)
  );

  assign s1_top = s1_par_r ? bank1_rd : bank0_rd;
  assign s1_mid = s1_par_r ? bank0_rd : bank1_rd;

  lbp_code_unit u_code (
    .clk            (clk),
    .rst_n          (rst_n),
    .s1_valid       (s1_valid_r),
    .s1_ctl         (s1_ctl_r),
    .s1_pixel       (s1_pixel_r),
    .s1_top         (s1_top),
    .s1_mid         (s1_mid),
    .advance        (advance),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_lbp_code   (out_lbp_code),
    .out_frame_last (out_frame_last)
  );

  `LBP_ASSERT_NEXT(a_cfg_restart, cfg_wr_en, (col_r == '0) && (row_r == '0), "frame not restarted")
  `LBP_ASSERT_ALWAYS(a_col_in_range, lbp_pkg::DIM_W'(col_r) < width_r, "column beyond width")
  `LBP_ASSERT_ALWAYS(a_row_in_range, lbp_pkg::DIM_W'(row_r) < height_r, "row beyond height")

endmodule

>>> dv/tb_lbp_3x3_image_stream.sv
// Self-checking testbench for lbp_3x3_image_stream: random and directed pixel frames
// are checked against a 3x3 local binary pattern predictor held in a scoreboard class.
// Depends on lbp_pkg and the lbp_3x3_image_stream RTL.
module tb_lbp_3x3_image_stream;

  localparam int          HOLD_CYCLES    = 300;
  localparam longint      LIMIT_CYCLES   = 1_000_000;
  localparam int          WR_BOTH        = 0;
  localparam int          WR_WIDTH_ONLY  = 1;
  localparam int          WR_HEIGHT_ONLY = 2;
  localparam int unsigned SMALL_ITEMS    = 860;

  typedef struct {
    logic [lbp_pkg::PIX_W-1:0] code;
    logic                      last;
  } lbp_result_t;

  class lbp_code_predictor;
    logic [lbp_pkg::PIX_W-1:0] line_mem [2*lbp_pkg::MAX_WIDTH];
    logic [lbp_pkg::PIX_W-1:0] win [3][3];
    int unsigned               col;
    int unsigned               row;
    logic [lbp_pkg::DIM_W-1:0] width_reg;
    logic [lbp_pkg::DIM_W-1:0] height_reg;
    lbp_result_t               expected_codes[$];
    int unsigned               mismatches;
    int unsigned               codes_checked;
    int unsigned               frame_ends;

    function new();
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      col        = 0;
      row        = 0;
      width_reg  = lbp_pkg::RST_WIDTH;
      height_reg = lbp_pkg::RST_HEIGHT;
      mismatches    = 0;
      codes_checked = 0;
      frame_ends    = 0;
    endfunction

    function int unsigned fit_dim(logic [lbp_pkg::DIM_W-1:0] v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned eff_width();
      return fit_dim(width_reg, lbp_pkg::MAX_WIDTH);
    endfunction

    function int unsigned eff_height();
      return fit_dim(height_reg, lbp_pkg::MAX_HEIGHT);
    endfunction

    function int unsigned outstanding();
      return expected_codes.size();
    endfunction

    function void write_reg(lbp_pkg::reg_idx_t idx, logic [lbp_pkg::DIM_W-1:0] val);
      if (idx == lbp_pkg::REG_IMAGE_WIDTH) width_reg = val;
      else height_reg = val;
      col = 0;
      row = 0;
    endfunction

    function void take_pixel(logic [lbp_pkg::PIX_W-1:0] px);
      int unsigned               w;
      int unsigned               h;
      int unsigned               old_i;
      int unsigned               prev_i;
      logic [lbp_pkg::PIX_W-1:0] ctr;
      logic [lbp_pkg::PIX_W-1:0] nb [8];
      lbp_result_t               res;
      w      = eff_width();
      h      = eff_height();
      old_i  = (row % 2) * lbp_pkg::MAX_WIDTH + col;
      prev_i = ((row + 1) % 2) * lbp_pkg::MAX_WIDTH + col;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = line_mem[old_i];
      win[1][2] = line_mem[prev_i];
      win[2][2] = px;
      line_mem[old_i] = px;
      if (row >= 2 && col >= 2) begin
        ctr   = win[1][1];
        nb[0] = win[0][0];
        nb[1] = win[0][1];
        nb[2] = win[0][2];
        nb[3] = win[1][0];
        nb[4] = win[1][2];
        nb[5] = win[2][0];
        nb[6] = win[2][1];
        nb[7] = win[2][2];
        for (int k = 0; k < lbp_pkg::NB_N; k++) res.code[k] = (nb[k] >= ctr);
        res.last = (row + 1 >= h) && (col + 1 >= w);
        expected_codes.push_back(res);
      end
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void match_code(logic [lbp_pkg::PIX_W-1:0] code, logic last);
      lbp_result_t exp_res;
      if (expected_codes.size() == 0) begin
        $error("unexpected result: lbp_code %02h frame_last %0b", code, last);
        mismatches++;
        return;
      end
      exp_res = expected_codes.pop_front();
      codes_checked++;
      if (last === 1'b1) frame_ends++;
      if (code !== exp_res.code) begin
        $error("lbp_code mismatch: expected %02h actual %02h", exp_res.code, code);
        mismatches++;
      end
      if (last !== exp_res.last) begin
        $error("frame_last mismatch: expected %0b actual %0b", exp_res.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [lbp_pkg::PIX_W-1:0] in_pixel;
  logic                      out_valid;
  logic                      out_ready;
  logic [lbp_pkg::PIX_W-1:0] out_lbp_code;
  logic                      out_frame_last;
  logic                      cfg_wr_en;
  logic [0:0]                cfg_index;
  logic [lbp_pkg::DIM_W-1:0] cfg_wdata;

  lbp_code_predictor pred = new();

  bit          hold_req;
  bit          steady_send;
  int unsigned burst_left;
  int unsigned pix_base;
  int unsigned pix_spread;
  int unsigned pixels_sent;
  int unsigned cfg_writes;
  int unsigned in_stalls;
  int unsigned holds_done;
  int unsigned drain_pauses;

  logic [lbp_pkg::PIX_W-1:0] corner_pix [27] = '{
    8'd0,   8'd255, 8'd128, 8'd127, 8'd128, 8'd129, 8'd128, 8'd255, 8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd254, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd0,   8'd254, 8'd255
  };

  lbp_3x3_image_stream dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_lbp_code   (out_lbp_code),
    .out_frame_last (out_frame_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * LIMIT_CYCLES);
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) pred.match_code(out_lbp_code, out_frame_last);
      if (in_valid && in_ready) pred.take_pixel(in_pixel);
      if (in_valid && !in_ready) in_stalls++;
    end
  end

  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned k;
    logic        v;
    out_ready = 1'b0;
    k = 0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 60);
        repeat (span) begin
          case (mode)
            0: v = 1'b1;
            1: v = ($urandom_range(0, 3) != 0);
            2: v = (k % 3 == 0);
            default: v = $urandom_range(0, 1);
          endcase
          out_ready <= v;
          @(negedge clk);
          k++;
        end
      end
    end
  end

  function automatic logic [lbp_pkg::PIX_W-1:0] rand_pixel();
    return lbp_pkg::PIX_W'(pix_base + $urandom_range(0, pix_spread));
  endfunction

  function automatic void pick_spread();
    if ($urandom_range(0, 2) == 0) begin
      pix_spread = 3;
      pix_base   = $urandom_range(0, 252);
    end else begin
      pix_spread = 255;
      pix_base   = 0;
    end
  endfunction

  task automatic feed_pixel(input logic [lbp_pkg::PIX_W-1:0] px);
    in_valid <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    pixels_sent++;
    if (!steady_send) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else if ($urandom_range(0, 299) == 0) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (pred.outstanding() != 0) @(negedge clk);
        drain_pauses++;
      end
    end
  endtask

  task automatic feed_run(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) feed_pixel(rand_pixel());
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pred.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input lbp_pkg::reg_idx_t idx,
                           input logic [lbp_pkg::DIM_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    pred.write_reg(idx, val);
    cfg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_dims(input logic [lbp_pkg::DIM_W-1:0] w_raw,
                          input logic [lbp_pkg::DIM_W-1:0] h_raw,
                          input int which);
    wait_idle();
    case (which)
      WR_WIDTH_ONLY: write_reg(lbp_pkg::REG_IMAGE_WIDTH, w_raw);
      WR_HEIGHT_ONLY: write_reg(lbp_pkg::REG_IMAGE_HEIGHT, h_raw);
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          write_reg(lbp_pkg::REG_IMAGE_WIDTH, w_raw);
          write_reg(lbp_pkg::REG_IMAGE_HEIGHT, h_raw);
        end else begin
          write_reg(lbp_pkg::REG_IMAGE_HEIGHT, h_raw);
          write_reg(lbp_pkg::REG_IMAGE_WIDTH, w_raw);
        end
      end
    endcase
  endtask

  initial begin
    int unsigned               small_items;
    int unsigned               frame_px;
    int unsigned               count;
    int unsigned               pick;
    int                        which;
    logic [lbp_pkg::DIM_W-1:0] w_raw;
    logic [lbp_pkg::DIM_W-1:0] h_raw;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_pixel    = '0;
    cfg_wr_en   = 1'b0;
    cfg_index   = lbp_pkg::REG_IMAGE_WIDTH;
    cfg_wdata   = '0;
    hold_req    = 1'b0;
    steady_send = 1'b0;
    burst_left  = 0;
    pix_base    = 0;
    pix_spread  = 255;
    small_items = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // three back-to-back 3x3 frames: mixed, all equal, bright centre
    set_dims(lbp_pkg::DIM_W'(3), lbp_pkg::DIM_W'(3), WR_BOTH);
    foreach (corner_pix[i]) feed_pixel(corner_pix[i]);

    // full frame; receiver holds off long enough to back up the input
    set_dims(lbp_pkg::DIM_W'(32), lbp_pkg::DIM_W'(8), WR_BOTH);
    pick_spread();
    steady_send = 1'b1;
    feed_run(50);
    hold_req = 1'b1;
    feed_run(32 * 8 - 50);
    steady_send = 1'b0;

    // narrow tall frame, both dimensions clamped, cut short by the next write
    set_dims(lbp_pkg::DIM_W'(0), lbp_pkg::DIM_W'(2047), WR_BOTH);
    pick_spread();
    feed_run(150);

    // wide frame, width clamped from above and height from below, cut short by the next write
    set_dims(lbp_pkg::DIM_W'(2047), lbp_pkg::DIM_W'(1), WR_BOTH);
    pick_spread();
    feed_run(100);

    while (small_items < SMALL_ITEMS) begin
      w_raw = ($urandom_range(0, 7) == 0) ? lbp_pkg::DIM_W'($urandom_range(0, 2))
                                           : lbp_pkg::DIM_W'($urandom_range(3, 10));
      pick  = $urandom_range(0, 9);
      if (pick == 0) h_raw = lbp_pkg::DIM_W'($urandom_range(0, 2));
      else if (pick == 1) h_raw = lbp_pkg::DIM_W'(2047);
      else h_raw = lbp_pkg::DIM_W'($urandom_range(3, 6));
      pick  = $urandom_range(0, 3);
      which = (pick == 0) ? WR_WIDTH_ONLY : (pick == 1) ? WR_HEIGHT_ONLY : WR_BOTH;
      set_dims(w_raw, h_raw, which);
      frame_px = pred.eff_width() * pred.eff_height();
      if (frame_px > 200 || $urandom_range(0, 3) == 0)
        count = $urandom_range(1, (frame_px > 80) ? 80 : frame_px - 1);
      else
        count = frame_px * $urandom_range(1, 3);
      pick_spread();
      steady_send = ($urandom_range(0, 4) == 0);
      feed_run(count);
      small_items += count;
    end
    steady_send = 1'b0;

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Sent %0d pixels over %0d register writes; checked %0d codes and %0d frame ends.",
             pixels_sent, cfg_writes, pred.codes_checked, pred.frame_ends);
    $display("Input stalled %0d cycles; %0d long output holds, %0d drain pauses.",
             in_stalls, holds_done, drain_pauses);
    if (pred.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> lbp_3x3_image_stream.f
+incdir+hdl
hdl/lbp_pkg.sv
hdl/lbp_line_ram.sv
hdl/lbp_code_unit.sv
hdl/lbp_3x3_image_stream.sv
dv/tb_lbp_3x3_image_stream.sv
